### rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro takes a label, a clock, an active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/vua_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vua_pkg;

	// Data path and field widths.
	localparam int DATA_W     = 32;
	localparam int KIND_W     = 4;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// Base of the percentage operations.
	localparam logic [DATA_W-1:0] PCT_BASE = DATA_W'(100);

	// Register indexes.
	localparam logic [APB_ADDR_W-3:0] REG_DEFAULT_INC = '0;

	// Operation codes.
	localparam logic [KIND_W-1:0] KIND_SET     = 4'd0;
	localparam logic [KIND_W-1:0] KIND_ADD     = 4'd1;
	localparam logic [KIND_W-1:0] KIND_INC     = 4'd2;
	localparam logic [KIND_W-1:0] KIND_SUB     = 4'd3;
	localparam logic [KIND_W-1:0] KIND_DEC     = 4'd4;
	localparam logic [KIND_W-1:0] KIND_ADD_PCT = 4'd5;
	localparam logic [KIND_W-1:0] KIND_SUB_PCT = 4'd6;
	localparam logic [KIND_W-1:0] KIND_MUL     = 4'd7;
	localparam logic [KIND_W-1:0] KIND_DIV     = 4'd8;
	localparam logic [KIND_W-1:0] KIND_NEG_ADD = 4'd9;
	localparam logic [KIND_W-1:0] KIND_NEG_SUB = 4'd10;
	localparam logic [KIND_W-1:0] KIND_MIN     = 4'd11;
	localparam logic [KIND_W-1:0] KIND_MAX     = 4'd12;
	localparam logic [KIND_W-1:0] KIND_RESET   = 4'd13;
	localparam logic [KIND_W-1:0] KIND_GET     = 4'd14;
	localparam logic [KIND_W-1:0] KIND_DEFAULT = 4'd15;

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [KIND_W-1:0] kind_t;

endpackage

`default_nettype wire

### rtl/vua_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Command channel: one beat carries one update request.
interface vua_cmd_if;
	import vua_pkg::*;

	logic  valid;
	logic  ready;
	kind_t kind;
	word_t operand;
	word_t current_value;

	modport source (output valid, output kind, output operand, output current_value,
		input ready);
	modport sink (input valid, input kind, input operand, input current_value,
		output ready);
endinterface

// Response channel: one beat carries one update result.
interface vua_rsp_if;
	import vua_pkg::*;

	logic  valid;
	logic  ready;
	word_t result_value;
	logic  write_back;
	logic  changed_notice;
	logic  get_report;

	modport source (output valid, output result_value, output write_back,
		output changed_notice, output get_report, input ready);
	modport sink (input valid, input result_value, input write_back,
		input changed_notice, input get_report, output ready);
endinterface

`default_nettype wire

### rtl/variable_update_alu_top.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted command goes from ST_IDLE through ST_EXEC to ST_FIN, which loads the
// response; divide and percent go through ST_EXEC, ST_PREP and ST_DIV (radix-2 divider,
// one quotient bit a cycle) before ST_FIN. ST_FIN waits while the response slot is full;
// a new command is taken only when the sequencer is idle.
// Reset (arst_n low, asynchronous): sequencer idle, no response pending,
// default_increment and the last reported value cleared.

module variable_update_alu_top (
	input  wire                                clk,
	input  wire                                arst_n,
	vua_cmd_if.sink                            cmd,
	vua_rsp_if.source                          rsp,
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire  [vua_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire  [vua_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [vua_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);
	import vua_pkg::*;

	localparam int CNT_W = $clog2(DATA_W);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]       state_q;
	kind_t            kind_q;
	word_t            opnd_q;
	word_t            cur_q;
	word_t            res_q;
	word_t            div_b_q;
	word_t            rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic             divzero_q;
	word_t            lr_q;
	logic             lr_valid_q;
	word_t            dinc_q;
	logic             rsp_valid_q;
	word_t            rsp_value_q;
	logic             rsp_wb_q;
	logic             rsp_chg_q;
	logic             rsp_get_q;

	logic             cmd_fire;
	logic             cfg_write;
	logic             slot_free;
	word_t            factor;
	word_t            mul_b;
	word_t            product;
	word_t            simple_nv;
	word_t            dividend;
	word_t            divisor;
	logic [DATA_W:0]  rem_sh;
	logic [DATA_W:0]  diff;
	logic             is_divk;
	logic             is_get;
	word_t            nv;
	logic             changed;

	// Handshakes.
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;

	// Configuration port: a single register, writes complete in the access phase.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_DEFAULT_INC) ? dinc_q : '0;

	// Shared multiplier for multiply and for the percentage factor.
	assign factor  = (kind_q == KIND_SUB_PCT) ? (PCT_BASE - opnd_q) : (PCT_BASE + opnd_q);
	assign mul_b   = (kind_q == KIND_MUL) ? opnd_q : factor;
	assign product = DATA_W'(cur_q * mul_b);

	// Operations that bypass the divider.
	always_comb begin
		case (kind_q)
			KIND_SET:     simple_nv = opnd_q;
			KIND_ADD:     simple_nv = cur_q + opnd_q;
			KIND_INC:     simple_nv = cur_q + DATA_W'(1);
			KIND_SUB:     simple_nv = cur_q - opnd_q;
			KIND_DEC:     simple_nv = cur_q - DATA_W'(1);
			KIND_MUL:     simple_nv = product;
			KIND_NEG_ADD: simple_nv = opnd_q - cur_q;
			KIND_NEG_SUB: simple_nv = DATA_W'(0) - opnd_q - cur_q;
			KIND_MIN:     simple_nv = ($signed(opnd_q) < $signed(cur_q)) ? opnd_q : cur_q;
			KIND_MAX:     simple_nv = ($signed(cur_q) < $signed(opnd_q)) ? opnd_q : cur_q;
			KIND_RESET:   simple_nv = '0;
			KIND_GET:     simple_nv = cur_q;
			KIND_DEFAULT: simple_nv = cur_q + dinc_q;
			default:      simple_nv = cur_q;
		endcase
	end

	// Divider operands: the percent path divides the registered product by the base.
	assign is_divk  = (kind_q == KIND_DIV) || (kind_q == KIND_ADD_PCT) ||
		(kind_q == KIND_SUB_PCT);
	assign dividend = res_q;
	assign divisor  = (kind_q == KIND_DIV) ? opnd_q : PCT_BASE;

	// One restoring step: shift in the next dividend bit and try the subtract.
	assign rem_sh = {rem_q, res_q[DATA_W-1]};
	assign diff   = rem_sh - {1'b0, div_b_q};

	// Final value, sign fixup and zero-divisor result for the divide kinds, and report flags.
	always_comb begin
		if (is_divk) begin
			if (divzero_q) begin
				nv = '0;
			end else if (neg_q) begin
				nv = DATA_W'(0) - res_q;
			end else begin
				nv = res_q;
			end
		end else begin
			nv = res_q;
		end
	end
	assign is_get  = (kind_q == KIND_GET);
	assign changed = !is_get && (nv != lr_q);

	// Sequencer, last reported value and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			lr_q        <= '0;
			lr_valid_q  <= 1'b0;
			dinc_q      <= '0;
		end else begin
			if (cfg_write && (paddr[APB_ADDR_W-1:2] == REG_DEFAULT_INC)) begin
				dinc_q <= pwdata[DATA_W-1:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						// The first command seeds the last reported value.
						if (!lr_valid_q) begin
							lr_q       <= cmd.current_value;
							lr_valid_q <= 1'b1;
						end
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= is_divk ? ST_PREP : ST_FIN;
				end
				ST_PREP: begin
					cnt_q   <= '1;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						if (changed) begin
							lr_q <= nv;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Response valid: set when the finished result is loaded, cleared once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Working registers and the response beat.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					kind_q <= cmd.kind;
					opnd_q <= cmd.operand;
					cur_q  <= cmd.current_value;
				end
			end
			ST_EXEC: begin
				if (kind_q == KIND_DIV) begin
					res_q <= cur_q;
				end else if (is_divk) begin
					res_q <= product;
				end else begin
					res_q <= simple_nv;
				end
			end
			ST_PREP: begin
				neg_q     <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
				divzero_q <= (divisor == '0);
				res_q     <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
				div_b_q   <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
				rem_q     <= '0;
			end
			ST_DIV: begin
				if (!diff[DATA_W]) begin
					rem_q <= diff[DATA_W-1:0];
					res_q <= {res_q[DATA_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[DATA_W-1:0];
					res_q <= {res_q[DATA_W-2:0], 1'b0};
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					rsp_value_q <= nv;
					rsp_wb_q    <= !is_get && (nv != cur_q);
					rsp_chg_q   <= changed;
					rsp_get_q   <= is_get;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.result_value   = rsp_value_q;
	assign rsp.write_back     = rsp_wb_q;
	assign rsp.changed_notice = rsp_chg_q;
	assign rsp.get_report     = rsp_get_q;

endmodule

`default_nettype wire

### rtl/vua_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vua_checker (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       cmd_valid,
	input wire                       cmd_ready,
	input wire                       rsp_valid,
	input wire                       rsp_ready,
	input wire [vua_pkg::DATA_W-1:0] rsp_result_value,
	input wire                       rsp_write_back,
	input wire                       rsp_changed_notice,
	input wire                       rsp_get_report
);
	import vua_pkg::*;

	logic cmd_beat;
	logic rsp_stall;

	assign cmd_beat  = cmd_valid && cmd_ready;
	assign rsp_stall = rsp_valid && !rsp_ready;

	// A stalled response beat stays offered with the same value.
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid && $stable(rsp_result_value))

	// A get report never asks for a write back or flags a change.
	`ASSERT_IMPLY(a_get_flags, clk, arst_n, rsp_valid && rsp_get_report,
		!rsp_write_back && !rsp_changed_notice)

	// The block takes one command at a time.
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, cmd_beat, !cmd_ready)

	// No response can appear in the cycle right after a command beat.
	`ASSERT_NEXT(a_min_latency, clk, arst_n, cmd_beat, !$rose(rsp_valid))

endmodule

bind variable_update_alu_top vua_checker u_vua_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.cmd_valid          (cmd.valid),
	.cmd_ready          (cmd.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_result_value   (rsp.result_value),
	.rsp_write_back     (rsp.write_back),
	.rsp_changed_notice (rsp.changed_notice),
	.rsp_get_report     (rsp.get_report)
);

`default_nettype wire

### test/variable_update_alu_top_tb.sv
`timescale 1ns / 1ps

module variable_update_alu_top_tb;
	import vua_pkg::*;

	typedef struct packed {
		kind_t kind;
		word_t operand;
		word_t current_value;
	} update_req_t;

	typedef struct packed {
		word_t value;
		logic  write_back;
		logic  changed_notice;
		logic  get_report;
	} update_res_t;

	localparam word_t WORD_MIN = 32'h8000_0000;
	localparam word_t WORD_MAX = 32'h7fff_ffff;
	localparam logic [APB_ADDR_W-1:0] ADDR_DEFAULT_INC = {REG_DEFAULT_INC, 2'b00};
	localparam int LONG_HOLD_CYCLES = 250;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	vua_cmd_if cmd_ch ();
	vua_rsp_if rsp_ch ();

	variable_update_alu_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the register and the last reported value.
	word_t default_inc;
	word_t last_value = '0;
	logic  last_valid = 1'b0;

	update_req_t queued_requests[$];
	update_res_t expected_updates[$];

	int error_count = 0;
	int results_seen = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	bit quiet_phase = 1'b0;

	// Signed division truncating toward zero; a zero divisor gives zero.
	function automatic word_t trunc_div(word_t num, word_t den);
		word_t mag_n;
		word_t mag_d;
		word_t quo;
		if (den == '0)
			return '0;
		mag_n = num[DATA_W-1] ? -num : num;
		mag_d = den[DATA_W-1] ? -den : den;
		quo = mag_n / mag_d;
		return (num[DATA_W-1] ^ den[DATA_W-1]) ? -quo : quo;
	endfunction

	// Works out the new variable value and flags, and updates the tracked value.
	function automatic update_res_t compute_update(update_req_t req);
		update_res_t res;
		word_t cur;
		word_t nv;
		cur = req.current_value;
		if (!last_valid) begin
			last_value = cur;
			last_valid = 1'b1;
		end
		if (req.kind == KIND_GET) begin
			res.value = cur;
			res.write_back = 1'b0;
			res.changed_notice = 1'b0;
			res.get_report = 1'b1;
			return res;
		end
		case (req.kind)
			KIND_SET:     nv = req.operand;
			KIND_ADD:     nv = cur + req.operand;
			KIND_INC:     nv = cur + 32'd1;
			KIND_SUB:     nv = cur - req.operand;
			KIND_DEC:     nv = cur - 32'd1;
			KIND_ADD_PCT: nv = trunc_div(cur * (PCT_BASE + req.operand), PCT_BASE);
			KIND_SUB_PCT: nv = trunc_div(cur * (PCT_BASE - req.operand), PCT_BASE);
			KIND_MUL:     nv = cur * req.operand;
			KIND_DIV:     nv = trunc_div(cur, req.operand);
			KIND_NEG_ADD: nv = req.operand - cur;
			KIND_NEG_SUB: nv = -req.operand - cur;
			KIND_MIN:     nv = ($signed(req.operand) < $signed(cur)) ? req.operand : cur;
			KIND_MAX:     nv = ($signed(cur) < $signed(req.operand)) ? req.operand : cur;
			KIND_RESET:   nv = '0;
			default:      nv = cur + default_inc;
		endcase
		res.value = nv;
		res.write_back = (nv != cur);
		res.changed_notice = (nv != last_value);
		res.get_report = 1'b0;
		if (res.changed_notice)
			last_value = nv;
		return res;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int idle_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		else if (pick < 90)
			return $urandom_range(1, 3);
		else if (pick < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Operand values biased toward extremes and small numbers.
	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return WORD_MIN;
					1: return WORD_MAX;
					2: return '0;
					3: return 32'd1;
					default: return '1;
				endcase
			end
			1, 2, 3: return word_t'($urandom_range(0, 600)) - 32'd300;
			default: return $urandom();
		endcase
	endfunction

	task automatic add_request(kind_t kind, word_t operand, word_t current_value);
		queued_requests.push_back('{kind, operand, current_value});
	endtask

	task automatic queue_random_requests(int count);
		update_req_t req;
		repeat (count) begin
			req.kind = kind_t'($urandom_range(0, 15));
			req.operand = pick_word();
			req.current_value = ($urandom_range(0, 9) == 0) ? req.operand : pick_word();
			queued_requests.push_back(req);
		end
	endtask

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_default_inc(word_t value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_DEFAULT_INC;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		default_inc = value;
	endtask

	// Waits until every request has gone in and every result has come back.
	// The check runs on the falling edge, after the rising-edge updates settle.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (!(queued_requests.size() == 0 && !cmd_ch.valid && expected_updates.size() == 0));
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(string name, word_t want, word_t got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
			error_count++;
		end
	endtask

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Command driver: offers queued requests and predicts each accepted beat.
	always @(posedge clk) begin
		logic        next_valid;
		update_req_t next_req;
		next_valid = cmd_ch.valid;
		next_req = '{cmd_ch.kind, cmd_ch.operand, cmd_ch.current_value};
		if (!arst_n) begin
			next_valid = 1'b0;
			next_req = '0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready)
				expected_updates.push_back(compute_update(next_req));
			if (!cmd_ch.valid || cmd_ch.ready) begin
				next_valid = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (queued_requests.size() > 0) begin
					next_req = queued_requests.pop_front();
					next_valid = 1'b1;
					send_gap = quiet_phase ? 0 : idle_gap();
				end
			end
		end
		cmd_ch.valid <= next_valid;
		cmd_ch.kind <= next_req.kind;
		cmd_ch.operand <= next_req.operand;
		cmd_ch.current_value <= next_req.current_value;
	end

	// Result monitor: compares each beat with the oldest prediction, drives ready.
	always @(posedge clk) begin
		logic        next_ready;
		update_res_t want;
		next_ready = rsp_ch.ready;
		if (!arst_n) begin
			next_ready = 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (expected_updates.size() == 0) begin
					$error("result beat with no request pending: value 0x%08h",
						rsp_ch.result_value);
					error_count++;
				end else begin
					want = expected_updates.pop_front();
					check_field("result_value", want.value, rsp_ch.result_value);
					check_field("write_back", word_t'(want.write_back),
						word_t'(rsp_ch.write_back));
					check_field("changed_notice", word_t'(want.changed_notice),
						word_t'(rsp_ch.changed_notice));
					check_field("get_report", word_t'(want.get_report),
						word_t'(rsp_ch.get_report));
				end
				// A long hold-off lets the block back up into its command side.
				if (results_seen == 300 || results_seen == 1000)
					hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
				recv_gap = quiet_phase ? 0 : idle_gap();
			end
		end
		rsp_ch.ready <= next_ready;
	end

	// Run limit.
	initial begin
		#4_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Stimulus sequence.
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		default_inc = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: first item as a get, wraparound at both ends,
		// percent with a wrapping factor, division corner cases.
		write_default_inc(32'd5);
		add_request(KIND_GET, '0, 32'd123);
		add_request(KIND_SET, 32'd123, '0);
		add_request(KIND_SET, WORD_MAX, WORD_MAX);
		add_request(KIND_ADD, 32'd1, WORD_MAX);
		add_request(KIND_INC, '0, WORD_MAX);
		add_request(KIND_SUB, 32'd1, WORD_MIN);
		add_request(KIND_DEC, '0, WORD_MIN);
		add_request(KIND_ADD_PCT, 32'd50, 32'd1000);
		add_request(KIND_ADD_PCT, WORD_MAX, 32'd3);
		add_request(KIND_SUB_PCT, 32'd150, 32'd1001);
		add_request(KIND_SUB_PCT, WORD_MIN, -32'sd7);
		add_request(KIND_MUL, WORD_MAX, WORD_MAX);
		add_request(KIND_MUL, '1, WORD_MIN);
		add_request(KIND_DIV, '0, 32'd77);
		add_request(KIND_DIV, '1, WORD_MIN);
		add_request(KIND_DIV, 32'd2, -32'sd7);
		add_request(KIND_DIV, -32'sd3, 32'd10);
		add_request(KIND_NEG_ADD, 32'd5, WORD_MIN);
		add_request(KIND_NEG_SUB, WORD_MIN, '0);
		add_request(KIND_MIN, '1, 32'd1);
		add_request(KIND_MAX, '1, 32'd1);
		add_request(KIND_MIN, WORD_MAX, WORD_MIN);
		add_request(KIND_RESET, 32'd99, '0);
		add_request(KIND_GET, WORD_MAX, -32'sd5);
		add_request(KIND_DEFAULT, '0, WORD_MAX);
		wait_idle();

		// Random phases over several increment settings.
		write_default_inc(WORD_MAX);
		queue_random_requests(350);
		wait_idle();

		quiet_phase = 1'b1;
		write_default_inc(WORD_MIN);
		queue_random_requests(350);
		wait_idle();
		quiet_phase = 1'b0;

		write_default_inc('0);
		queue_random_requests(350);
		wait_idle();

		write_default_inc($urandom());
		queue_random_requests(350);
		wait_idle();

		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
